// ===== rtl/mtg_pkg.sv =====
// Shared constants, types and the tempering function of the MT19937 generator.
package mtg_pkg;

  localparam int MT_N = 624;
  localparam int MT_M = 397;
  localparam int IDX_W = 10;

  localparam logic [31:0] MT_MATRIX   = 32'h9908_B0DF;
  localparam logic [31:0] MT_TEMPER_B = 32'h9D2C_5680;
  localparam logic [31:0] MT_TEMPER_C = 32'hEFC6_0000;
  localparam logic [31:0] MT_MULT     = 32'd1812433253;
  localparam logic [31:0] SEED_RESET  = 32'd5489;

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(MT_N - 1);
  localparam logic [IDX_W-1:0] IDX_WRAP_M = IDX_W'(MT_N - MT_M);
  localparam logic [IDX_W-1:0] IDX_OFS_M  = IDX_W'(MT_M);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_READ,
    ST_WRITE
  } mtg_state_t;

  typedef struct packed {
    logic seed_init;
    logic seed_mul;
    logic seed_add;
    logic rd;
    logic commit;
  } mtg_cmd_t;

  typedef struct packed {
    logic seed_last;
  } mtg_sts_t;

  function automatic logic [31:0] mt_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== rtl/mtg_intf.sv =====
// Handshake channels of the MT19937 generator: request, result word and seed write.
interface mtg_req_if;
  logic valid;
  logic ready;
  logic reseed;
  modport source (output valid, output reseed, input ready);
  modport sink (input valid, input reseed, output ready);
endinterface

interface mtg_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

interface mtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed_value;
  modport source (output valid, output seed_value, input ready);
  modport sink (input valid, input seed_value, output ready);
endinterface

// ===== rtl/mtg_ctrl.sv =====
// Controller state machine: sequences seeding passes and per-word twist/draw steps.
module mtg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_reseed,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output mtg_pkg::mtg_cmd_t cmd,
  input  mtg_pkg::mtg_sts_t sts
);
  import mtg_pkg::*;

  mtg_state_t state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       commit;
  logic       accept;

  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_WRITE) && out_free;
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = in_reseed ? ST_SEED_INIT : ST_READ;
      end
      ST_SEED_INIT: state_nxt = ST_SEED_MUL;
      ST_SEED_MUL:  state_nxt = ST_SEED_ADD;
      ST_SEED_ADD: begin
        if (sts.seed_last) state_nxt = pend_r ? ST_READ : ST_IDLE;
        else state_nxt = ST_SEED_MUL;
      end
      ST_READ: state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (commit) begin
          if (accept) state_nxt = in_reseed ? ST_SEED_INIT : ST_READ;
          else state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.seed_init = (state_r == ST_SEED_INIT);
    cmd.seed_mul  = (state_r == ST_SEED_MUL);
    cmd.seed_add  = (state_r == ST_SEED_ADD);
    cmd.rd        = (state_r == ST_READ);
    cmd.commit    = commit;
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept && in_reseed) pend_nxt = 1'b1;
    else if ((state_r == ST_SEED_ADD) && sts.seed_last) pend_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED_INIT;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("completed draw did not present a word");

  a_reseed_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_reseed) |=> (state_r == ST_SEED_INIT))
    else $error("reseed transaction did not start a seeding pass");

  a_reset_pass_idles: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SEED_ADD) && sts.seed_last && !pend_r) |=> (state_r == ST_IDLE))
    else $error("reset seeding pass did not end idle");

  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_WRITE))
    else $error("table read not followed by write step");

  a_no_accept_seeding: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SEED_MUL) || (state_r == ST_SEED_ADD)) |-> !in_ready)
    else $error("request taken during seeding");
`endif

endmodule

// ===== rtl/mtg_datapath.sv =====
// Datapath: state table, seed recurrence, per-word twist, tempering and output word.
module mtg_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  mtg_pkg::mtg_cmd_t cmd,
  output mtg_pkg::mtg_sts_t sts,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  output logic [31:0]       out_word
);
  import mtg_pkg::*;

  logic [31:0]      table_mem [MT_N];
  logic [31:0]      seed_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      w_r, w_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [31:0]      cache_r;
  logic [31:0]      rd_p1_r;
  logic [31:0]      rd_m_r;
  logic [31:0]      out_word_r;
  logic [31:0]      mul_in;
  logic [31:0]      twist_y;
  logic [31:0]      twist_v;
  logic [IDX_W-1:0] addr_p1;
  logic [IDX_W-1:0] addr_m;
  logic [IDX_W-1:0] idx_inc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  assign sts.seed_last = (idx_r == IDX_LAST);

  assign idx_inc = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
  assign addr_p1 = idx_inc;
  assign addr_m  = (idx_r >= IDX_WRAP_M) ? idx_r - IDX_WRAP_M : idx_r + IDX_OFS_M;

  assign mul_in   = w_r ^ (w_r >> 30);
  assign prod_nxt = MT_MULT * mul_in;
  assign w_nxt    = prod_r + {{(32-IDX_W){1'b0}}, idx_r};

  assign twist_y = {cache_r[31], rd_p1_r[30:0]};
  assign twist_v = rd_m_r ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : 32'd0);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.seed_init) idx_nxt = IDX_W'(1);
    else if (cmd.seed_add || cmd.commit) idx_nxt = idx_inc;
  end

  assign wr_en   = cmd.seed_init || cmd.seed_add || cmd.commit;
  assign wr_addr = cmd.seed_init ? '0 : idx_r;

  always_comb begin
    wr_data = twist_v;
    if (cmd.seed_init) wr_data = seed_r;
    else if (cmd.seed_add) wr_data = w_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
      idx_r  <= '0;
    end else begin
      if (cfg_we) seed_r <= cfg_data;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      w_r     <= seed_r;
      cache_r <= seed_r;
    end
    if (cmd.seed_add) w_r <= w_nxt;
    if (cmd.seed_mul) prod_r <= prod_nxt;
    if (cmd.commit) begin
      cache_r    <= rd_p1_r;
      out_word_r <= mt_temper(twist_v);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
    if (cmd.rd) begin
      rd_p1_r <= table_mem[addr_p1];
      rd_m_r  <= table_mem[addr_m];
    end
  end

  assign out_word = out_word_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("table index beyond last entry");

  a_seed_start: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd.seed_init) |=> (idx_r == IDX_W'(1)))
    else $error("seeding pass did not start at entry one");

  a_draw_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (idx_r == IDX_LAST)) |=> (idx_r == '0))
    else $error("read index did not wrap after last entry");
`endif

endmodule

// ===== rtl/mersenne_twister_generator.sv =====
// MT19937 generator: each request transaction returns one tempered 32-bit word.
// Each draw has a read step, reading entries i+1 and i+397 of the two-read-port
// state table, and a write step, which twists entry i, writes it back and loads the
// tempered word into the output register (entry i is carried over from the previous
// draw), waits while the previous word is untaken and can take the next request. A
// reseed request first runs a seeding pass, whose recurrence goes through one 32x32
// multiplier; the same pass runs after reset, and no request is taken until it ends.
// Seed writes are always taken; a new seed is used only by the next reseed request.
module mersenne_twister_generator (
  input logic        clk,
  input logic        rst_n,
  mtg_req_if.sink    in_req,
  mtg_word_if.source out_word,
  mtg_cfg_if.sink    cfg_wr
);
  import mtg_pkg::*;

  mtg_cmd_t cmd;
  mtg_sts_t sts;

  assign cfg_wr.ready = 1'b1;

  mtg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_reseed (in_req.reseed),
    .in_ready  (in_req.ready),
    .out_ready (out_word.ready),
    .out_valid (out_word.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  mtg_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_wr.valid),
    .cfg_data (cfg_wr.seed_value),
    .out_word (out_word.random_word)
  );

endmodule

// ===== bench/mtg_word_checker.sv =====
// Checker for the MT19937 generator: predicts each word and compares results in order.
`timescale 1ns / 100ps

module mtg_word_checker (
  input  logic clk,
  input  logic rst_n,
  mtg_req_if   req,
  mtg_word_if  word,
  mtg_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding
);
  import mtg_pkg::*;

  logic [31:0] seed_reg;
  logic [31:0] mt_state [MT_N];
  int unsigned draw_pos;
  logic [31:0] expected_words [$];
  int          reported;

  function automatic void seed_state();
    logic [31:0] prev;
    mt_state[0] = seed_reg;
    for (int i = 1; i < MT_N; i++) begin
      prev = mt_state[i-1];
      mt_state[i] = MT_MULT * (prev ^ (prev >> 30)) + 32'(i);
    end
  endfunction

  function automatic void twist_state();
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < MT_N; i++) begin
      y = {mt_state[i][31], mt_state[(i + 1) % MT_N][30:0]};
      v = mt_state[(i + MT_M) % MT_N] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ MT_MATRIX;
      end
      mt_state[i] = v;
    end
  endfunction

  function automatic logic [31:0] tempered(input logic [31:0] x);
    logic [31:0] t;
    t = x ^ {11'd0, x[31:11]};
    t = t ^ ({t[24:0], 7'd0} & MT_TEMPER_B);
    t = t ^ ({t[16:0], 15'd0} & MT_TEMPER_C);
    return t ^ {18'd0, t[31:18]};
  endfunction

  function automatic logic [31:0] draw_word(input logic reseed);
    logic [31:0] w;
    if (reseed) begin
      seed_state();
      draw_pos = 0;
    end
    if (draw_pos == 0) begin
      twist_state();
    end
    w = tempered(mt_state[draw_pos]);
    draw_pos = (draw_pos == MT_N - 1) ? 0 : draw_pos + 1;
    return w;
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      seed_reg = SEED_RESET;
      seed_state();
      draw_pos = 0;
      expected_words.delete();
      fail_count = 0;
      reported = 0;
    end else begin
      if (word.valid && word.ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected word %08h", $realtime, word.random_word);
          end
        end else begin
          want = expected_words.pop_front();
          if (word.random_word !== want) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: random_word expected %08h, got %08h", $realtime, want,
                       word.random_word);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_words.push_back(draw_word(req.reseed));
      end
      if (cfg.valid && cfg.ready) begin
        seed_reg = cfg.seed_value;
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

// ===== bench/mersenne_twister_generator_test.sv =====
// Top of the MT19937 generator testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module mersenne_twister_generator_test;
  import mtg_pkg::*;

  localparam int PERIOD      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 8000;
  localparam int LONG_RUN    = 630;
  localparam int SEG_ITEMS   = 12;

  logic clk = 1'b0;
  logic rst_n;
  bit   gaps_on = 1'b1;
  bit   hold_off = 1'b0;
  int   fail_count;
  int   outstanding;

  mtg_req_if  req_ch ();
  mtg_word_if word_ch ();
  mtg_cfg_if  seed_ch ();

  mersenne_twister_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_word (word_ch),
    .cfg_wr   (seed_ch)
  );

  mtg_word_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .word        (word_ch),
    .cfg         (seed_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_req(input logic reseed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.reseed <= reseed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding word
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    seed_ch.valid      <= 1'b1;
    seed_ch.seed_value <= seed;
    @(posedge clk);
    while (!seed_ch.ready) @(posedge clk);
    seed_ch.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int idle_left;
    idle_left = 0;
    word_ch.ready <= 1'b0;
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        word_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (word_ch.valid && word_ch.ready) begin
        idle_left = pick_gap();
      end
      if (idle_left > 0) begin
        word_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        word_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (word_ch.valid && word_ch.ready) ||
          (seed_ch.valid && seed_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] seed;
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.reseed      <= 1'b0;
    seed_ch.valid      <= 1'b0;
    seed_ch.seed_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset seed, then the seed extremes
    repeat (4) send_req(1'b0);
    settle();
    write_seed(32'h0000_0000);
    send_req(1'b1);
    repeat (2) send_req(1'b0);
    settle();
    write_seed(32'hFFFF_FFFF);
    send_req(1'b1);
    repeat (2) send_req(1'b0);
    send_req(1'b1);
    send_req(1'b1);
    send_req(1'b0);
    settle();
    // new seed stays unused until a reseed
    write_seed(32'h0000_0001);
    repeat (2) send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);
    settle();

    // long run past the table wrap, with one long receiver stall
    write_seed($urandom);
    send_req(1'b1);
    for (int n = 0; n < LONG_RUN; n++) begin
      if (n == 300) hold_off = 1'b1;
      send_req(1'b0);
    end

    for (int seg = 0; seg < 4; seg++) begin
      settle();
      case ($urandom_range(0, 3))
        0:       seed = 32'h0000_0000;
        1:       seed = 32'hFFFF_FFFF;
        2:       seed = SEED_RESET;
        default: seed = $urandom;
      endcase
      write_seed(seed);
      gaps_on = (seg != 1);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send_req($urandom_range(0, 11) == 0);
      end
    end
    gaps_on = 1'b1;

    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mtg_pkg.sv
rtl/mtg_intf.sv
rtl/mtg_ctrl.sv
rtl/mtg_datapath.sv
rtl/mersenne_twister_generator.sv
bench/mtg_word_checker.sv
bench/mersenne_twister_generator_test.sv
